/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ppc_pkg.sv */
// ----------------------------------------------------------------------------
// ppc_pkg
// types and constants of the polygon point classifier
// ----------------------------------------------------------------------------
package ppc_pkg;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [1:0] STATUS_NORMAL  = 2'd0;
   localparam logic [1:0] STATUS_FEW     = 2'd1;
   localparam logic [1:0] STATUS_DROPPED = 2'd2;

   localparam int DIST_BITS = 23;
   localparam logic [DIST_BITS-1:0] DIST_MAX = 23'h7FFFFF;

   localparam int T_SHIFT = 16;
   localparam int T_BITS  = T_SHIFT + 1;
   localparam logic [T_BITS-1:0] T_ONE = 17'h10000;
   localparam int DIV_STEPS = 16;

   localparam int ROOT_BITS = DIST_BITS;
   localparam int SQ_BITS   = 2 * ROOT_BITS;
   localparam int SQ_LO     = 2 * T_SHIFT;
   localparam int REM_BITS  = ROOT_BITS + 4;

   localparam int SQ_STEPS = 6;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RDA, ST_LDA, ST_RDB, ST_LDB,
      ST_C1, ST_C2, ST_C3, ST_C4,
      ST_V2, ST_V3, ST_D1, ST_D2, ST_D3, ST_DCHK, ST_DIV,
      ST_X1, ST_X2, ST_X3, ST_X4,
      ST_SQ, ST_SQD, ST_RT0, ST_RT, ST_MIN, ST_NEXT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MAC_NONE, MAC_LOAD, MAC_ADD, MAC_SUB
   } mac_op_type;

   typedef enum logic [1:0] {
      SH_0, SH_H1, SH_2H
   } mac_shift_type;

   typedef struct packed {
      mac_op_type    op;
      mac_shift_type sh;
   } mac_cmd_type;

endpackage

/* rtl/polygon_point_classifier.sv */
// load item: written to the vertex memory, or dropped and flagged once the memory is full
// query item: handles the stored edges in turn with the single shared multiplier and
// the one-bit-per-cycle divide and square root steps; the block takes no item meanwhile
// a finished result waits in the output register while loads and a new query are taken
// reset: no vertices held, next load starts a new polygon, no result pending
// ----------------------------------------------------------------------------
// polygon_point_classifier
// even-odd inside test and nearest edge distance over a stored polygon
// ----------------------------------------------------------------------------
module polygon_point_classifier #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 22
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_inside_res,
   output logic [ppc_pkg::DIST_BITS-1:0] rsp_edge_distance,
   output logic [1:0]                   rsp_status
);
   import ppc_pkg::*;

   localparam int AWD = $clog2(MAX_VERTICES);
   localparam int CW  = AWD + 1;
   localparam int CB  = COORD_BITS;
   localparam int DW  = CB + 1;
   localparam int HW  = (CB + 18) / 2;
   localparam int SW0 = (DW > HW + 1) ? DW : HW + 1;
   localparam int SW  = (SW0 > 18) ? SW0 : 18;
   localparam int PW  = 2 * SW;
   localparam int DXW = CB + 18;
   localparam int AW0 = 4 * HW + 3;
   localparam int AW  = (AW0 > SQ_LO + SQ_BITS + 2) ? AW0 : SQ_LO + SQ_BITS + 2;

   state_type state_ff, state_in;
   logic [CW-1:0] total_ff, total_in, n_ff, n_in, i_ff, i_in, nm1, base_total;
   logic closed_ff, closed_in, ovf_ff, ovf_in, base_ovf;
   logic signed [CB-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CB-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [CB-1:0] rd_x, rd_y;
   logic signed [DW-1:0] vx_ff, vx_in, vy_ff, vy_in, wx_ff, wx_in, wy_ff, wy_in;
   logic signed [DW-1:0] ux_ff, ux_in, uy_ff, uy_in;
   logic cr_ff, cr_in, inside_ff, inside_in;
   logic signed [SW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff, prod_in;
   mac_cmd_type cmd_ff, cmd_in;
   logic signed [AW-1:0] acc_ff, acc_in, vv_ff, vv_in, prod_ext, acc_sh, rem2;
   logic [T_BITS-1:0] t_ff, t_in;
   logic [4:0] k_ff, k_in;
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in, dx_abs, dy_abs;
   logic [2*HW-1:0] dxm_ff, dxm_in, dym_ff, dym_in;
   logic [SQ_BITS-1:0] sq_ff, sq_in;
   logic [REM_BITS-1:0] rrem_ff, rrem_in, rq2, trial;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [DIST_BITS-1:0] best_ff, best_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;
   logic [DIST_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic mem_we;
   logic [AWD-1:0] waddr, raddr;
   logic [2*CB-1:0] mem [MAX_VERTICES];
   logic [2*CB-1:0] rdata_ff;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inside_res    = rsp_inside_ff;
   assign rsp_edge_distance = rsp_dist_ff;
   assign rsp_status        = rsp_status_ff;

   assign nm1  = n_ff - CW'(1);
   assign rd_x = $signed(rdata_ff[2*CB-1:CB]);
   assign rd_y = $signed(rdata_ff[CB-1:0]);

   assign prod_in  = PW'(mul_a) * PW'(mul_b);
   assign prod_ext = AW'(prod_ff);
   assign rem2     = acc_ff <<< 1;
   assign dx_abs   = (dx_ff < 0) ? -dx_ff : dx_ff;
   assign dy_abs   = (dy_ff < 0) ? -dy_ff : dy_ff;
   assign rq2      = {rrem_ff[REM_BITS-3:0], sq_ff[SQ_BITS-1 -: 2]};
   assign trial    = {2'b00, root_ff, 2'b01};

   always_comb begin
      case (cmd_ff.sh)
         SH_H1:   acc_sh = prod_ext <<< (HW + 1);
         SH_2H:   acc_sh = prod_ext <<< (2 * HW);
         default: acc_sh = prod_ext;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= {px_in, py_in};
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         closed_ff    <= 1'b1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '{op: MAC_NONE, sh: SH_0};
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         closed_ff    <= closed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      wx_ff         <= wx_in;
      wy_ff         <= wy_in;
      ux_ff         <= ux_in;
      uy_ff         <= uy_in;
      cr_ff         <= cr_in;
      inside_ff     <= inside_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      vv_ff         <= vv_in;
      t_ff          <= t_in;
      k_ff          <= k_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dxm_ff        <= dxm_in;
      dym_ff        <= dym_in;
      sq_ff         <= sq_in;
      rrem_ff       <= rrem_in;
      root_ff       <= root_in;
      best_ff       <= best_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      closed_in     = closed_ff;
      ovf_in        = ovf_ff;
      base_total    = closed_ff ? '0 : total_ff;
      base_ovf      = closed_ff ? 1'b0 : ovf_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      wx_in         = wx_ff;
      wy_in         = wy_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      cr_in         = cr_ff;
      inside_in     = inside_ff;
      cmd_in        = '{op: MAC_NONE, sh: SH_0};
      mul_a         = vx_ff;
      mul_b         = uy_ff;
      vv_in         = vv_ff;
      t_in          = t_ff;
      k_in          = k_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dxm_in        = dxm_ff;
      dym_in        = dym_ff;
      sq_in         = sq_ff;
      rrem_in       = rrem_ff;
      root_in       = root_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      waddr         = base_total[AWD-1:0];
      raddr         = i_ff[AWD-1:0];

      case (cmd_ff.op)
         MAC_LOAD: acc_in = acc_sh;
         MAC_ADD:  acc_in = acc_ff + acc_sh;
         MAC_SUB:  acc_in = acc_ff - acc_sh;
         default:  acc_in = acc_ff;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in = req_coord_x;
               py_in = req_coord_y;
               if (req_action == ACT_LOAD) begin
                  closed_in = req_last_vertex;
                  if (base_total < CW'(MAX_VERTICES)) begin
                     mem_we   = 1'b1;
                     total_in = base_total + CW'(1);
                     ovf_in   = base_ovf;
                  end else begin
                     total_in = base_total;
                     ovf_in   = 1'b1;
                  end
               end else begin
                  n_in      = total_ff;
                  i_in      = '0;
                  inside_in = 1'b0;
                  best_in   = DIST_MAX;
                  state_in  = (total_ff == '0) ? ST_DONE : ST_RDA;
               end
            end
         end
         ST_RDA: begin
            raddr    = nm1[AWD-1:0];
            state_in = ST_LDA;
         end
         ST_LDA: begin
            ax_in    = rd_x;
            ay_in    = rd_y;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            state_in = ST_LDB;
         end
         ST_LDB: begin
            bx_in    = rd_x;
            by_in    = rd_y;
            vx_in    = DW'(rd_x) - DW'(ax_ff);
            vy_in    = DW'(rd_y) - DW'(ay_ff);
            wx_in    = DW'(px_ff) - DW'(ax_ff);
            wy_in    = DW'(py_ff) - DW'(ay_ff);
            ux_in    = DW'(px_ff) - DW'(rd_x);
            uy_in    = DW'(py_ff) - DW'(rd_y);
            cr_in    = (rd_y > py_ff) != (ay_ff > py_ff);
            state_in = ST_C1;
         end
         ST_C1: begin
            mul_a    = SW'(vx_ff);
            mul_b    = SW'(uy_ff);
            cmd_in   = '{op: MAC_LOAD, sh: SH_0};
            state_in = ST_C2;
         end
         ST_C2: begin
            mul_a    = SW'(vy_ff);
            mul_b    = SW'(ux_ff);
            cmd_in   = '{op: MAC_SUB, sh: SH_0};
            state_in = ST_C3;
         end
         ST_C3: begin
            state_in = ST_C4;
         end
         ST_C4: begin
            if (cr_ff && ((vy_ff < 0 && acc_ff < 0) || (vy_ff > 0 && acc_ff > 0))) begin
               inside_in = !inside_ff;
            end
            if (i_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               mul_a    = SW'(vx_ff);
               mul_b    = SW'(vx_ff);
               cmd_in   = '{op: MAC_LOAD, sh: SH_0};
               state_in = ST_V2;
            end
         end
         ST_V2: begin
            mul_a    = SW'(vy_ff);
            mul_b    = SW'(vy_ff);
            cmd_in   = '{op: MAC_ADD, sh: SH_0};
            state_in = ST_V3;
         end
         ST_V3: begin
            state_in = ST_D1;
         end
         ST_D1: begin
            vv_in    = acc_ff;
            mul_a    = SW'(wx_ff);
            mul_b    = SW'(vx_ff);
            cmd_in   = '{op: MAC_LOAD, sh: SH_0};
            state_in = ST_D2;
         end
         ST_D2: begin
            mul_a    = SW'(wy_ff);
            mul_b    = SW'(vy_ff);
            cmd_in   = '{op: MAC_ADD, sh: SH_0};
            state_in = ST_D3;
         end
         ST_D3: begin
            state_in = ST_DCHK;
         end
         ST_DCHK: begin
            k_in = '0;
            if (acc_ff <= 0) begin
               t_in     = '0;
               state_in = ST_X1;
            end else if (acc_ff >= vv_ff) begin
               t_in     = T_ONE;
               state_in = ST_X1;
            end else begin
               t_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem2 >= vv_ff) begin
               acc_in = rem2 - vv_ff;
               t_in   = {t_ff[T_BITS-2:0], 1'b1};
            end else begin
               acc_in = rem2;
               t_in   = {t_ff[T_BITS-2:0], 1'b0};
            end
            k_in = k_ff + 5'd1;
            if (k_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_X1;
            end
         end
         ST_X1: begin
            mul_a    = SW'(t_ff);
            mul_b    = SW'(vx_ff);
            state_in = ST_X2;
         end
         ST_X2: begin
            dx_in    = (DXW'(wx_ff) <<< T_SHIFT) - DXW'(prod_ff);
            mul_a    = SW'(t_ff);
            mul_b    = SW'(vy_ff);
            state_in = ST_X3;
         end
         ST_X3: begin
            dy_in    = (DXW'(wy_ff) <<< T_SHIFT) - DXW'(prod_ff);
            dxm_in   = dx_abs[2*HW-1:0];
            state_in = ST_X4;
         end
         ST_X4: begin
            dym_in   = dy_abs[2*HW-1:0];
            k_in     = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            k_in = k_ff + 5'd1;
            case (k_ff)
               5'd0: begin
                  mul_a  = SW'(dxm_ff[2*HW-1:HW]);
                  mul_b  = SW'(dxm_ff[2*HW-1:HW]);
                  cmd_in = '{op: MAC_LOAD, sh: SH_2H};
               end
               5'd1: begin
                  mul_a  = SW'(dxm_ff[2*HW-1:HW]);
                  mul_b  = SW'(dxm_ff[HW-1:0]);
                  cmd_in = '{op: MAC_ADD, sh: SH_H1};
               end
               5'd2: begin
                  mul_a  = SW'(dxm_ff[HW-1:0]);
                  mul_b  = SW'(dxm_ff[HW-1:0]);
                  cmd_in = '{op: MAC_ADD, sh: SH_0};
               end
               5'd3: begin
                  mul_a  = SW'(dym_ff[2*HW-1:HW]);
                  mul_b  = SW'(dym_ff[2*HW-1:HW]);
                  cmd_in = '{op: MAC_ADD, sh: SH_2H};
               end
               5'd4: begin
                  mul_a  = SW'(dym_ff[2*HW-1:HW]);
                  mul_b  = SW'(dym_ff[HW-1:0]);
                  cmd_in = '{op: MAC_ADD, sh: SH_H1};
               end
               default: begin
                  mul_a  = SW'(dym_ff[HW-1:0]);
                  mul_b  = SW'(dym_ff[HW-1:0]);
                  cmd_in = '{op: MAC_ADD, sh: SH_0};
               end
            endcase
            if (k_ff == 5'(SQ_STEPS - 1)) begin
               state_in = ST_SQD;
            end
         end
         ST_SQD: begin
            state_in = ST_RT0;
         end
         ST_RT0: begin
            sq_in   = acc_ff[SQ_LO +: SQ_BITS];
            rrem_in = '0;
            root_in = '0;
            k_in    = '0;
            // squared distance too large to beat the saturated value
            if (|acc_ff[AW-1:SQ_LO+SQ_BITS]) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_RT;
            end
         end
         ST_RT: begin
            sq_in = sq_ff << 2;
            if (rq2 >= trial) begin
               rrem_in = rq2 - trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rrem_in = rq2;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            k_in = k_ff + 5'd1;
            if (k_ff == 5'(ROOT_BITS - 1)) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            if (root_ff < best_ff) begin
               best_in = root_ff;
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            ax_in = bx_ff;
            ay_in = by_ff;
            if (i_ff == nm1) begin
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = ST_RDB;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = inside_ff;
               rsp_dist_in   = (n_ff < CW'(2)) ? '0 : best_ff;
               if (ovf_ff) begin
                  rsp_status_in = STATUS_DROPPED;
               end else if (n_ff < CW'(2)) begin
                  rsp_status_in = STATUS_FEW;
               end else begin
                  rsp_status_in = STATUS_NORMAL;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`include "assert_macros.svh"

   `ASSERT_IMP(a_total_cap, clock, reset, 1'b1, total_ff <= CW'(MAX_VERTICES), "vertex count above capacity")
   `ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result not from done state")
   `ASSERT_NXT(a_empty_query, clock, reset, req_valid && req_ready && req_action == ACT_QUERY && total_ff == '0, state_ff == ST_DONE, "empty polygon query not finished at once")
   `ASSERT_IMP(a_status_code, clock, reset, rsp_valid_ff, rsp_status_ff != 2'd3, "undefined status code")

endmodule
